[rtl/fgs_pkg.sv]
// Shared types and constants for the function group sequencer.
// No dependencies; imported by every module of the block.
package fgs_pkg;

  // Fixed field widths
  localparam int MODE_W = 2;
  localparam int GRP_W  = 2;
  localparam int MEM_W  = 3;
  localparam int FLAG_W = 1 << MEM_W;
  localparam int CNT_W  = 4;
  localparam int TICK_W = 16;
  localparam int MASK_W = 4;
  localparam int CFG_W  = 16;

  // Command codes
  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_NOTIFY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

  // Lifecycle state codes
  localparam logic [1:0] ST_OFF      = 2'd0;
  localparam logic [1:0] ST_STARTING = 2'd1;
  localparam logic [1:0] ST_ON       = 2'd2;
  localparam logic [1:0] ST_STOPPING = 2'd3;

  // Configuration register indexes
  localparam logic REG_MEMBER_COUNTS = 1'b0;
  localparam logic REG_TIMEOUT_TICKS = 1'b1;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  // Registered command broadcast to every group
  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] mode;
    logic [MEM_W-1:0]  member;
    logic              member_active;
  } fgs_cmd_t;

  // Per-group result of one step
  typedef struct packed {
    logic [1:0]       state_nxt;
    logic [CNT_W-1:0] count_nxt;
    logic             changed;
    logic             timed_out;
    logic             member_err;
  } fgs_grp_stat_t;

endpackage

[rtl/fgs_group.sv]
// Lifecycle state, member flags, active count and tick counter of one group.
// Depends on fgs_pkg.
module fgs_group import fgs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  fgs_cmd_t            cmd,
  input  logic                sel,
  input  logic [CNT_W-1:0]    required,
  input  logic [TICK_W-1:0]   timeout_ticks,
  output fgs_grp_stat_t       stat
);

  logic [1:0]        state_r, state_nxt;
  logic [FLAG_W-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TICK_W-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_W-1:0] elapsed_inc;
  logic              in_trans;
  logic              timed_out;
  logic              member_err;

  // Saturating tick count and transition flag
  assign elapsed_inc = (elapsed_r == TICK_MAX) ? elapsed_r : elapsed_r + TICK_W'(1);
  assign in_trans    = (state_r == ST_STARTING) || (state_r == ST_STOPPING);

  // Next state for one transaction
  always_comb begin
    state_nxt   = state_r;
    flags_nxt   = flags_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    timed_out   = 1'b0;
    member_err  = 1'b0;
    if (cmd.valid) begin
      unique case (cmd.mode)
        MODE_TICK: begin
          if (in_trans) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > timeout_ticks) begin
              state_nxt = (state_r == ST_STARTING) ? ST_ON : ST_OFF;
              timed_out = 1'b1;
            end else if (state_r == ST_STARTING) begin
              if (count_r >= required) state_nxt = ST_ON;
            end else if (count_r == '0) begin
              state_nxt = ST_OFF;
            end
          end
        end
        MODE_START: begin
          if (sel && state_r != ST_ON) begin
            state_nxt   = ST_STARTING;
            elapsed_nxt = '0;
          end
        end
        MODE_STOP: begin
          if (sel && state_r != ST_OFF) begin
            state_nxt   = ST_STOPPING;
            elapsed_nxt = '0;
          end
        end
        MODE_NOTIFY: begin
          if (sel) begin
            if (CNT_W'(cmd.member) >= required) begin
              member_err = 1'b1;
            end else if (flags_r[cmd.member] != cmd.member_active) begin
              flags_nxt[cmd.member] = cmd.member_active;
              count_nxt = cmd.member_active ? count_r + CNT_W'(1) : count_r - CNT_W'(1);
            end
          end
        end
      endcase
    end
  end

  // Hold group state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_OFF;
      flags_r   <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
    end else begin
      state_r   <= state_nxt;
      flags_r   <= flags_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign stat.state_nxt  = state_nxt;
  assign stat.count_nxt  = count_nxt;
  assign stat.changed    = (state_nxt != state_r);
  assign stat.timed_out  = timed_out;
  assign stat.member_err = member_err;

endmodule

[rtl/fgs_out.sv]
// Result stage: picks the addressed group, builds the masks, registers the result.
// Depends on fgs_pkg.
module fgs_out import fgs_pkg::*; #(
  parameter int GROUPS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fgs_cmd_t            cmd,
  input  logic [GRP_W-1:0]    group,
  input  fgs_grp_stat_t       stat [GROUPS],
  output logic                out_valid,
  output logic                out_status,
  output logic [1:0]          out_group_state,
  output logic                out_stable,
  output logic [CNT_W-1:0]    out_active_count,
  output logic [MASK_W-1:0]   out_changed_mask,
  output logic [MASK_W-1:0]   out_timeout_mask
);

  logic              valid_r;
  logic              status_r, status_nxt;
  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MASK_W-1:0] changed_r, changed_nxt;
  logic [MASK_W-1:0] tmask_r, tmask_nxt;
  logic              grp_ok;
  logic              err_sel;

  assign grp_ok = (32'(group) < GROUPS);

  // Select addressed group and gather masks
  always_comb begin
    state_nxt   = ST_OFF;
    count_nxt   = '0;
    err_sel     = 1'b0;
    changed_nxt = '0;
    tmask_nxt   = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (32'(group) == g) begin
        state_nxt = stat[g].state_nxt;
        count_nxt = stat[g].count_nxt;
        err_sel   = stat[g].member_err;
      end
    end
    for (int g = 0; g < MASK_W; g++) begin
      if (g < GROUPS) begin
        changed_nxt[g] = stat[g].changed;
        tmask_nxt[g]   = stat[g].timed_out;
      end
    end
    if (cmd.mode == MODE_TICK) status_nxt = 1'b0;
    else if (!grp_ok)          status_nxt = 1'b1;
    else                       status_nxt = err_sel;
  end

  // Strobe register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      status_r  <= status_nxt;
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      changed_r <= changed_nxt;
      tmask_r   <= tmask_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_group_state  = state_r;
  assign out_stable       = (state_r == ST_OFF) || (state_r == ST_ON);
  assign out_active_count = count_r;
  assign out_changed_mask = changed_r;
  assign out_timeout_mask = tmask_r;

endmodule

[rtl/function_group_sequencer.sv]
// Function group sequencer: lifecycle of GROUPS function groups.
// A command accepted into the input register has its result strobe raised from the
// result register in fgs_out. Throughput: one command per cycle while busy is low;
// the group state update and result register sit in one stage behind the input
// register. The receiver cannot stall.
// Reset (rst_n low, synchronous): all groups OFF, flags, counts and tick counters
// cleared, member_counts 0, timeout_ticks 1000; busy is high during reset and is
// cleared at the first clock edge with rst_n high.
module function_group_sequencer import fgs_pkg::*; #(
  parameter int GROUPS  = 4,
  parameter int MEMBERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [GRP_W-1:0]  in_group,
  input  logic [MEM_W-1:0]  in_member,
  input  logic              in_member_active,
  output logic              out_valid,
  output logic              out_status,
  output logic [1:0]        out_group_state,
  output logic              out_stable,
  output logic [CNT_W-1:0]  out_active_count,
  output logic [MASK_W-1:0] out_changed_mask,
  output logic [MASK_W-1:0] out_timeout_mask,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam logic [CNT_W-1:0] MEMBERS_MAX = CNT_W'(MEMBERS);

  logic              busy_r;
  fgs_cmd_t          cmd_r;
  logic [GRP_W-1:0]  group_r;
  logic [CFG_W-1:0]  member_counts_r;
  logic [TICK_W-1:0] timeout_r;
  logic [CNT_W-1:0]  required [GROUPS];
  fgs_grp_stat_t     stat [GROUPS];
  logic              accept;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Busy only while coming out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r.valid <= 1'b0;
    end else begin
      cmd_r.valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.mode          <= in_mode;
      cmd_r.member        <= in_member;
      cmd_r.member_active <= in_member_active;
      group_r             <= in_group;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      member_counts_r <= '0;
      timeout_r       <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MEMBER_COUNTS: member_counts_r <= cfg_data;
        REG_TIMEOUT_TICKS: timeout_r       <= cfg_data;
      endcase
    end
  end

  // Group units with their clamped required counts
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    logic sel;
    if (g < MASK_W) begin : g_req
      logic [CNT_W-1:0] nib;
      assign nib         = member_counts_r[CNT_W*g +: CNT_W];
      assign required[g] = (nib > MEMBERS_MAX) ? MEMBERS_MAX : nib;
    end else begin : g_noreq
      assign required[g] = '0;
    end
    assign sel = (32'(group_r) == g);

    fgs_group u_group (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cmd_r),
      .sel           (sel),
      .required      (required[g]),
      .timeout_ticks (timeout_r),
      .stat          (stat[g])
    );
  end

  fgs_out #(.GROUPS(GROUPS)) u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd_r),
    .group            (group_r),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_group_state  (out_group_state),
    .out_stable       (out_stable),
    .out_active_count (out_active_count),
    .out_changed_mask (out_changed_mask),
    .out_timeout_mask (out_timeout_mask)
  );

endmodule

[rtl/fgs_checker.sv]
// Port-level checks for the function group sequencer, bound to the top level.
// Depends on fgs_pkg and function_group_sequencer.
module fgs_port_checks import fgs_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [MODE_W-1:0] in_mode,
  input logic              out_valid,
  input logic [1:0]        out_group_state,
  input logic              out_stable,
  input logic [MASK_W-1:0] out_changed_mask,
  input logic [MASK_W-1:0] out_timeout_mask
);

  // Every accepted transaction gives a result behind the input and result registers
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  // No result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted transaction");

  // A timed-out group also changed state
  a_timeout_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_timeout_mask & ~out_changed_mask) == '0))
    else $error("timeout without state change");

  // Only ticks can time out a group
  a_timeout_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(in_mode, 2) == MODE_TICK || out_timeout_mask == '0))
    else $error("timeout mask set outside a tick");

  // Stable flag agrees with the reported state
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_stable == (out_group_state == ST_OFF || out_group_state == ST_ON)))
    else $error("stable flag disagrees with group state");

endmodule

bind function_group_sequencer fgs_port_checks u_fgs_port_checks (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_group_state  (out_group_state),
  .out_stable       (out_stable),
  .out_changed_mask (out_changed_mask),
  .out_timeout_mask (out_timeout_mask)
);

[test/fgs_checker.sv]
// Result checker for the function group sequencer: watches the command, result
// and register channels, keeps its own copy of the group state and compares.
// Depends on fgs_pkg for field widths, command, state and register codes.
module fgs_checker import fgs_pkg::*; #(
  parameter int GROUPS  = 4,
  parameter int MEMBERS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [GRP_W-1:0]  in_group,
  input  logic [MEM_W-1:0]  in_member,
  input  logic              in_member_active,
  input  logic              out_valid,
  input  logic              out_status,
  input  logic [1:0]        out_group_state,
  input  logic              out_stable,
  input  logic [CNT_W-1:0]  out_active_count,
  input  logic [MASK_W-1:0] out_changed_mask,
  input  logic [MASK_W-1:0] out_timeout_mask,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending,
  output int                checked,
  output int                forced
);

  typedef struct packed {
    logic              status;
    logic [1:0]        group_state;
    logic              stable;
    logic [CNT_W-1:0]  active_count;
    logic [MASK_W-1:0] changed_mask;
    logic [MASK_W-1:0] timeout_mask;
  } grp_result_t;

  // Shadow copy of the block's state and registers
  logic [1:0]        life     [GROUPS];
  logic [FLAG_W-1:0] flags    [GROUPS];
  logic [CNT_W-1:0]  n_active [GROUPS];
  logic [TICK_W-1:0] elapsed  [GROUPS];
  logic [CFG_W-1:0]  req_word;
  logic [CFG_W-1:0]  tmo_limit;

  grp_result_t expected_q [$];
  int bad_n     = 0;
  int checked_n = 0;
  int forced_n  = 0;

  assign fail_count = bad_n;
  assign pending    = expected_q.size();
  assign checked    = checked_n;
  assign forced     = forced_n;

  // Required member count of a group, clamped to the member count
  function automatic int required_members(input int g);
    int n;
    if (g >= 4) return 0;
    n = req_word[4*g +: 4];
    return (n > MEMBERS) ? MEMBERS : n;
  endfunction

  function automatic string describe(input grp_result_t r);
    return $sformatf("status=%0d state=%0d stable=%0d count=%0d changed=%b timeout=%b",
                     r.status, r.group_state, r.stable, r.active_count,
                     r.changed_mask, r.timeout_mask);
  endfunction

  // Advance the shadow state by one command and return its result
  function automatic grp_result_t advance_groups(input logic [MODE_W-1:0] mode,
                                                 input logic [GRP_W-1:0]  grp,
                                                 input logic [MEM_W-1:0]  mem,
                                                 input logic              act);
    grp_result_t r;
    logic [1:0]  prior;
    logic [1:0]  target;
    bit          in_range;
    r = '0;
    in_range = int'(grp) < GROUPS;
    if (mode == MODE_TICK) begin
      for (int g = 0; g < GROUPS; g++) begin
        if (life[g] == ST_STARTING || life[g] == ST_STOPPING) begin
          target = (life[g] == ST_STARTING) ? ST_ON : ST_OFF;
          if (elapsed[g] != TICK_MAX) elapsed[g]++;
          if (elapsed[g] > tmo_limit) begin
            life[g] = target;
            forced_n++;
            if (g < MASK_W) begin
              r.changed_mask[g] = 1'b1;
              r.timeout_mask[g] = 1'b1;
            end
          end else if (target == ST_ON) begin
            if (int'(n_active[g]) >= required_members(g)) begin
              life[g] = ST_ON;
              if (g < MASK_W) r.changed_mask[g] = 1'b1;
            end
          end else if (n_active[g] == '0) begin
            life[g] = ST_OFF;
            if (g < MASK_W) r.changed_mask[g] = 1'b1;
          end
        end
      end
    end else if (!in_range) begin
      r.status = 1'b1;
    end else if (mode == MODE_START || mode == MODE_STOP) begin
      prior = life[grp];
      if (mode == MODE_START && prior != ST_ON) begin
        life[grp]    = ST_STARTING;
        elapsed[grp] = '0;
      end else if (mode == MODE_STOP && prior != ST_OFF) begin
        life[grp]    = ST_STOPPING;
        elapsed[grp] = '0;
      end
      if (life[grp] != prior && int'(grp) < MASK_W) r.changed_mask[grp] = 1'b1;
    end else begin
      // Member notification: reject members at or beyond the required count
      if (int'(mem) >= required_members(grp)) begin
        r.status = 1'b1;
      end else if (flags[grp][mem] != act) begin
        flags[grp][mem] = act;
        if (act) n_active[grp]++;
        else n_active[grp]--;
      end
    end
    if (in_range) begin
      r.group_state  = life[grp];
      r.stable       = (life[grp] == ST_OFF || life[grp] == ST_ON);
      r.active_count = n_active[grp];
    end else begin
      r.stable = 1'b1;
    end
    return r;
  endfunction

  // Compare results, then record new commands and register writes
  always @(posedge clk) begin
    grp_result_t seen;
    grp_result_t want;
    if (!rst_n) begin
      for (int g = 0; g < GROUPS; g++) begin
        life[g]     = ST_OFF;
        flags[g]    = '0;
        n_active[g] = '0;
        elapsed[g]  = '0;
      end
      req_word  = '0;
      tmo_limit = TIMEOUT_RESET;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        seen = {out_status, out_group_state, out_stable, out_active_count,
                out_changed_mask, out_timeout_mask};
        if (expected_q.size() == 0) begin
          if (bad_n < 10) $display("unexpected result transaction: %s", describe(seen));
          bad_n++;
        end else begin
          want = expected_q.pop_front();
          checked_n++;
          if (seen !== want) begin
            if (bad_n < 10) begin
              $display("result %0d mismatch", checked_n);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(seen));
            end
            bad_n++;
          end
        end
      end
      if (start && !busy)
        expected_q.push_back(advance_groups(in_mode, in_group, in_member, in_member_active));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MEMBER_COUNTS) req_word = cfg_data;
        else tmo_limit = cfg_data;
      end
    end
  end

endmodule

[test/tb_function_group_sequencer.sv]
// Top of the function group sequencer testbench: clock, reset, command and
// register stimulus, watchdog and verdict. Depends on fgs_pkg, the block and fgs_checker.
module tb_function_group_sequencer;
  import fgs_pkg::*;

  localparam int GROUPS      = 4;
  localparam int MEMBERS     = 8;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 130;
  localparam int SOAK_TICKS  = 24;
  localparam int STALL_LIMIT = 1000;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [MODE_W-1:0] in_mode;
  logic [GRP_W-1:0]  in_group;
  logic [MEM_W-1:0]  in_member;
  logic              in_member_active;
  logic              out_valid;
  logic              out_status;
  logic [1:0]        out_group_state;
  logic              out_stable;
  logic [CNT_W-1:0]  out_active_count;
  logic [MASK_W-1:0] out_changed_mask;
  logic [MASK_W-1:0] out_timeout_mask;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  int fail_count;
  int pending;
  int checked;
  int forced;

  int n_mode [4];
  int n_items      = 0;
  int n_writes     = 0;
  int stall_cycles = 0;
  bit idling_on;
  logic [CFG_W-1:0] counts_now;

  function_group_sequencer #(.GROUPS(GROUPS), .MEMBERS(MEMBERS)) DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_group(in_group), .in_member(in_member),
    .in_member_active(in_member_active),
    .out_valid(out_valid), .out_status(out_status), .out_group_state(out_group_state),
    .out_stable(out_stable), .out_active_count(out_active_count),
    .out_changed_mask(out_changed_mask), .out_timeout_mask(out_timeout_mask),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  fgs_checker #(.GROUPS(GROUPS), .MEMBERS(MEMBERS)) u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_group(in_group), .in_member(in_member),
    .in_member_active(in_member_active),
    .out_valid(out_valid), .out_status(out_status), .out_group_state(out_group_state),
    .out_stable(out_stable), .out_active_count(out_active_count),
    .out_changed_mask(out_changed_mask), .out_timeout_mask(out_timeout_mask),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked), .forced(forced)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort when no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic int req_of(input int g);
    int n;
    n = counts_now[4*g +: 4];
    return (n > MEMBERS) ? MEMBERS : n;
  endfunction

  // Mostly pick a member the group accepts, sometimes any member
  function automatic logic [MEM_W-1:0] pick_member(input int g);
    if (req_of(g) > 0 && $urandom_range(0, 4) != 0)
      return MEM_W'($urandom_range(0, req_of(g) - 1));
    return MEM_W'($urandom_range(0, 7));
  endfunction

  // Send one command and hold it until the block takes it
  task automatic issue(input logic [MODE_W-1:0] mode, input logic [GRP_W-1:0] grp,
                       input logic [MEM_W-1:0] mem, input logic act);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start            <= 1'b1;
    in_mode          <= mode;
    in_group         <= grp;
    in_member        <= mem;
    in_member_active <= act;
    do @(posedge clk); while (busy);
    n_mode[mode]++;
    n_items++;
  endtask

  task automatic random_tick();
    issue(MODE_TICK, GRP_W'($urandom_range(0, 3)), MEM_W'($urandom_range(0, 7)),
          1'($urandom_range(0, 1)));
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MEMBER_COUNTS) counts_now = value;
    n_writes++;
  endtask

  initial begin
    int g;
    int k;
    int phase_end;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_mode          = MODE_START;
    in_group         = '0;
    in_member        = '0;
    in_member_active = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_MEMBER_COUNTS;
    cfg_data         = '0;
    counts_now       = '0;
    idling_on        = 1'b1;
    foreach (n_mode[i]) n_mode[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: no members required, long timeout
    issue(MODE_TICK,   2'd0, 3'd0, 1'b0);   // nothing in transition
    issue(MODE_STOP,   2'd0, 3'd0, 1'b0);   // stop while off
    issue(MODE_START,  2'd0, 3'd0, 1'b0);
    issue(MODE_START,  2'd0, 3'd0, 1'b0);   // repeated start
    issue(MODE_NOTIFY, 2'd0, 3'd7, 1'b1);   // member beyond a zero count
    issue(MODE_TICK,   2'd0, 3'd0, 1'b0);   // zero required reaches on
    issue(MODE_START,  2'd0, 3'd0, 1'b0);   // start while on
    issue(MODE_STOP,   2'd0, 3'd0, 1'b0);
    issue(MODE_START,  2'd0, 3'd0, 1'b0);   // reverse to starting
    issue(MODE_STOP,   2'd0, 3'd0, 1'b0);   // reverse to stopping
    issue(MODE_TICK,   2'd3, 3'd7, 1'b1);   // no members active, reach off

    // Counts 1, 2, 15 (clamped) and 8; immediate timeout
    write_reg(REG_MEMBER_COUNTS, 16'h8F21);
    write_reg(REG_TIMEOUT_TICKS, 16'd0);
    issue(MODE_NOTIFY, 2'd1, 3'd1, 1'b1);
    issue(MODE_NOTIFY, 2'd1, 3'd1, 1'b1);   // already active
    issue(MODE_NOTIFY, 2'd1, 3'd2, 1'b1);   // at the required count
    issue(MODE_NOTIFY, 2'd2, 3'd7, 1'b1);
    issue(MODE_START,  2'd2, 3'd0, 1'b0);
    issue(MODE_START,  2'd3, 3'd0, 1'b0);
    issue(MODE_TICK,   2'd1, 3'd0, 1'b0);   // both forced on by timeout
    issue(MODE_NOTIFY, 2'd1, 3'd1, 1'b0);

    // Lower the counts with a flag still set, never time out
    write_reg(REG_MEMBER_COUNTS, 16'h0000);
    write_reg(REG_TIMEOUT_TICKS, TICK_MAX);
    issue(MODE_STOP,   2'd2, 3'd0, 1'b0);
    issue(MODE_TICK,   2'd2, 3'd0, 1'b0);   // stale flag keeps it stopping
    issue(MODE_NOTIFY, 2'd2, 3'd7, 1'b0);   // cannot clear it now

    // Random phases: mostly bring-up and shutdown sequences, some noise
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(REG_MEMBER_COUNTS, 16'hFFFF);
          write_reg(REG_TIMEOUT_TICKS, 16'd5);
        end
        1: begin
          write_reg(REG_MEMBER_COUNTS, 16'h0000);
          write_reg(REG_TIMEOUT_TICKS, TICK_MAX);
        end
        2: begin
          write_reg(REG_MEMBER_COUNTS, CFG_W'($urandom_range(0, 16'hFFFF)));
          write_reg(REG_TIMEOUT_TICKS, 16'd0);
        end
        5: begin
          write_reg(REG_MEMBER_COUNTS, CFG_W'($urandom_range(0, 16'hFFFF)));
          write_reg(REG_TIMEOUT_TICKS, CFG_W'($urandom_range(0, 16'hFFFF)));
        end
        default: begin
          write_reg(REG_MEMBER_COUNTS, CFG_W'($urandom_range(0, 16'hFFFF)));
          write_reg(REG_TIMEOUT_TICKS, CFG_W'($urandom_range(1, 12)));
        end
      endcase
      idling_on = (p != N_PHASES - 1);
      phase_end = n_items + PHASE_ITEMS;
      while (n_items < phase_end) begin
        g = $urandom_range(0, 3);
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            issue(MODE_START, GRP_W'(g), MEM_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            k = $urandom_range(1, 8);
            repeat (k) issue(MODE_NOTIFY, GRP_W'(g), pick_member(g), $urandom_range(0, 4) != 0);
            repeat ($urandom_range(1, 3)) random_tick();
          end
          3, 4: begin
            issue(MODE_STOP, GRP_W'(g), MEM_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            k = $urandom_range(1, 8);
            repeat (k) issue(MODE_NOTIFY, GRP_W'(g), pick_member(g), $urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) random_tick();
          end
          5, 6: begin
            repeat ($urandom_range(1, 4)) random_tick();
          end
          default: begin
            issue(MODE_W'($urandom_range(0, 3)), GRP_W'(g), MEM_W'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)));
          end
        endcase
      end
    end

    // Hold group 0 stuck starting and group 1 stuck stopping, then force both by timeout
    idling_on = 1'b0;
    write_reg(REG_MEMBER_COUNTS, 16'h0018);
    write_reg(REG_TIMEOUT_TICKS, TICK_MAX);
    for (int m = 0; m < MEMBERS; m++) issue(MODE_NOTIFY, 2'd0, MEM_W'(m), 1'b0);
    issue(MODE_NOTIFY, 2'd1, 3'd0, 1'b1);
    issue(MODE_STOP,   2'd0, 3'd0, 1'b0);
    issue(MODE_START,  2'd0, 3'd0, 1'b0);
    issue(MODE_START,  2'd1, 3'd0, 1'b0);
    issue(MODE_STOP,   2'd1, 3'd0, 1'b0);
    repeat (SOAK_TICKS) random_tick();
    write_reg(REG_TIMEOUT_TICKS, 16'd10);
    random_tick();
    random_tick();

    drain();
    repeat (8) @(posedge clk);
    $display("Covered %0d commands (%0d start, %0d stop, %0d notify, %0d tick),",
             n_items, n_mode[MODE_START], n_mode[MODE_STOP], n_mode[MODE_NOTIFY],
             n_mode[MODE_TICK]);
    $display("%0d register writes; compared %0d results, %0d forced timeouts, %0d mismatches",
             n_writes, checked, forced, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
